// ===== rtl/wake_request_sequencer_core_macros.svh =====
// assertion macros for the wake request sequencer
// expects clk and rst_n in the scope of use
`ifndef WAKE_REQUEST_SEQUENCER_CORE_MACROS_SVH
`define WAKE_REQUEST_SEQUENCER_CORE_MACROS_SVH

// checked only out of reset
`define WRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define WRS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/wrs_pkg.sv =====
// wake request sequencer package: phase codes, register map, reset values
// and the structs shared by the step logic and the top level; no dependencies
`default_nettype none

package wrs_pkg;

    localparam int TIMER_BITS_DEFAULT = 20;
    localparam int CFG_W = 20;
    localparam int CNT_W = 4;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_OBSERVE    = 3'd1,
        PH_CONNECTING = 3'd2,
        PH_BACKOFF    = 3'd3,
        PH_SENDING    = 3'd4,
        PH_CLEANUP    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        LINK_PENDING = 2'd0,
        LINK_UP      = 2'd1,
        LINK_BADAUTH = 2'd2,
        LINK_FAIL    = 2'd3
    } link_t;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_OBSERVE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PKT_TOTAL = 3'd6;

    localparam logic [CFG_W-1:0] RST_OBSERVE  = 20'd3000;
    localparam logic [CFG_W-1:0] RST_TIMEOUT  = 20'd20000;
    localparam logic [CFG_W-1:0] RST_DEBOUNCE = 20'd90000;
    localparam logic [CFG_W-1:0] RST_BACKOFF  = 20'd1500;
    localparam logic [CFG_W-1:0] RST_GAP      = 20'd200;
    localparam logic [CNT_W-1:0] RST_RETRY_LIM = 4'd2;
    localparam logic [CNT_W-1:0] RST_PKT_TOTAL = 4'd3;

    typedef struct packed {
        logic [CFG_W-1:0] observe_ticks;
        logic [CFG_W-1:0] connect_timeout_ticks;
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] backoff_ticks;
        logic [CFG_W-1:0] packet_gap_ticks;
        logic [CNT_W-1:0] retry_limit;
        logic [CNT_W-1:0] packet_total;
    } cfg_t;

    typedef struct packed {
        phase_t           phase;
        logic             request_taken;
        logic             hold_poweroff;
        logic             release_poweroff;
        logic             start_link;
        logic             send_packet;
        logic             link_down;
        logic [CNT_W-1:0] retries_used;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/wrs_step.sv =====
// wake request sequencer step: next phase, timers, counters and result
// pulses for one item; uses wrs_pkg
`default_nettype none

module wrs_step #(
    parameter int TIMER_BITS = wrs_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic                       cmd,
    input  wire logic                       host_active,
    input  wire logic [1:0]                 link_status,
    input  wire wrs_pkg::cfg_t              cfg,
    input  wire wrs_pkg::phase_t            phase_cur,
    input  wire logic [TIMER_BITS-1:0]      phase_timer_cur,
    input  wire logic [TIMER_BITS-1:0]      since_attempt_cur,
    input  wire logic                       attempt_seen_cur,
    input  wire logic [wrs_pkg::CNT_W-1:0]  retry_count_cur,
    input  wire logic [wrs_pkg::CNT_W-1:0]  sent_count_cur,
    output wrs_pkg::phase_t                 phase_nxt,
    output logic [TIMER_BITS-1:0]           phase_timer_nxt,
    output logic [TIMER_BITS-1:0]           since_attempt_nxt,
    output logic                            attempt_seen_nxt,
    output logic [wrs_pkg::CNT_W-1:0]       retry_count_nxt,
    output logic [wrs_pkg::CNT_W-1:0]       sent_count_nxt,
    output wrs_pkg::result_t                res
);
    import wrs_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    logic [TIMER_BITS-1:0] pt_inc;
    logic [TIMER_BITS-1:0] sa_inc;
    logic [CMP_W-1:0]      pt_ext;
    logic [CNT_W-1:0]      sent_inc;
    logic                  debounce_ok;

    assign pt_inc   = (phase_timer_cur == TMAX) ? TMAX : phase_timer_cur + 1'b1;
    assign sa_inc   = (since_attempt_cur == TMAX) ? TMAX : since_attempt_cur + 1'b1;
    assign pt_ext   = CMP_W'(pt_inc);
    assign sent_inc = sent_count_cur + 1'b1;
    assign debounce_ok = !attempt_seen_cur ||
                         (CMP_W'(since_attempt_cur) >= CMP_W'(cfg.debounce_ticks));

    always_comb
    begin
        phase_nxt         = phase_cur;
        phase_timer_nxt   = phase_timer_cur;
        since_attempt_nxt = since_attempt_cur;
        attempt_seen_nxt  = attempt_seen_cur;
        retry_count_nxt   = retry_count_cur;
        sent_count_nxt    = sent_count_cur;
        res               = '0;

        if (cmd == CMD_REQUEST)
        begin
            if (phase_cur == PH_IDLE && debounce_ok)
            begin
                attempt_seen_nxt  = 1'b1;
                since_attempt_nxt = '0;
                retry_count_nxt   = '0;
                phase_timer_nxt   = '0;
                phase_nxt         = PH_OBSERVE;
                res.request_taken = 1'b1;
                res.hold_poweroff = 1'b1;
            end
        end
        else
        begin
            since_attempt_nxt = sa_inc;
            case (phase_cur)
                PH_OBSERVE:
                begin
                    if (host_active)
                    begin
                        res.release_poweroff = 1'b1;
                        phase_nxt = PH_IDLE;
                    end
                    else if (pt_ext > CMP_W'(cfg.observe_ticks))
                    begin
                        res.start_link  = 1'b1;
                        phase_timer_nxt = '0;
                        phase_nxt       = PH_CONNECTING;
                    end
                    else
                    begin
                        phase_timer_nxt = pt_inc;
                    end
                end
                PH_CONNECTING:
                begin
                    phase_timer_nxt = pt_inc;
                    if (link_status == LINK_UP)
                    begin
                        sent_count_nxt  = '0;
                        phase_timer_nxt = '0;
                        phase_nxt       = PH_SENDING;
                    end
                    else if (link_status == LINK_BADAUTH)
                    begin
                        phase_nxt = PH_CLEANUP;
                    end
                    else if (link_status == LINK_FAIL ||
                             pt_ext > CMP_W'(cfg.connect_timeout_ticks))
                    begin
                        if (retry_count_cur < cfg.retry_limit)
                        begin
                            retry_count_nxt = retry_count_cur + 1'b1;
                            phase_timer_nxt = '0;
                            phase_nxt       = PH_BACKOFF;
                        end
                        else
                        begin
                            phase_nxt = PH_CLEANUP;
                        end
                    end
                end
                PH_BACKOFF:
                begin
                    if (pt_ext > CMP_W'(cfg.backoff_ticks))
                    begin
                        res.start_link  = 1'b1;
                        phase_timer_nxt = '0;
                        phase_nxt       = PH_CONNECTING;
                    end
                    else
                    begin
                        phase_timer_nxt = pt_inc;
                    end
                end
                PH_SENDING:
                begin
                    if (sent_count_cur == '0 || pt_ext >= CMP_W'(cfg.packet_gap_ticks))
                    begin
                        res.send_packet = 1'b1;
                        sent_count_nxt  = sent_inc;
                        phase_timer_nxt = '0;
                        if (sent_inc >= cfg.packet_total)
                        begin
                            phase_nxt = PH_CLEANUP;
                        end
                    end
                    else
                    begin
                        phase_timer_nxt = pt_inc;
                    end
                end
                PH_CLEANUP:
                begin
                    res.link_down = 1'b1;
                    phase_nxt     = PH_IDLE;
                end
                default:
                begin
                    phase_nxt = phase_cur;
                end
            endcase
        end

        res.phase        = phase_nxt;
        res.retries_used = retry_count_nxt;
    end

endmodule

`default_nettype wire

// ===== rtl/wake_request_sequencer_core.sv =====
// wake request sequencer top level: register file, input stage, sequencer
// state and result register; uses wrs_pkg, wrs_step and the assertion macros
`default_nettype none

`include "wake_request_sequencer_core_macros.svh"

// Takes one item per clock unless stalled (a wake request or a time tick)
// and gives one result item per input item: the item is held in the input
// register, then goes through the step logic into the result register.
// Sustained rate is one item per clock while out_ready is held high; the
// input side keeps taking items while a result waits, until both stages are
// full. The user must write registers through cfg_we, cfg_index and cfg_data only
// while the block is idle, which the block itself does not enforce; indexes past the register list are ignored.
module wake_request_sequencer_core #(
    parameter int TIMER_BITS = wrs_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [wrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wrs_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic                          host_active,
    input  wire logic [1:0]                    link_status,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [2:0]                         phase,
    output logic                               request_taken,
    output logic                               hold_poweroff,
    output logic                               release_poweroff,
    output logic                               start_link,
    output logic                               send_packet,
    output logic                               link_down,
    output logic [wrs_pkg::CNT_W-1:0]          retries_used
);
    import wrs_pkg::*;

    cfg_t                  cfg_reg;
    logic                  in_valid_reg;
    logic                  cmd_reg;
    logic                  host_reg;
    logic [1:0]            link_reg;
    logic                  out_valid_reg;
    result_t               res_reg;

    phase_t                phase_reg;
    logic [TIMER_BITS-1:0] phase_timer_reg;
    logic [TIMER_BITS-1:0] since_attempt_reg;
    logic                  attempt_seen_reg;
    logic [CNT_W-1:0]      retry_count_reg;
    logic [CNT_W-1:0]      sent_count_reg;

    phase_t                phase_next;
    logic [TIMER_BITS-1:0] phase_timer_next;
    logic [TIMER_BITS-1:0] since_attempt_next;
    logic                  attempt_seen_next;
    logic [CNT_W-1:0]      retry_count_next;
    logic [CNT_W-1:0]      sent_count_next;
    result_t               res_next;

    logic                  advance;
    logic                  fire;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.observe_ticks         <= RST_OBSERVE;
            cfg_reg.connect_timeout_ticks <= RST_TIMEOUT;
            cfg_reg.debounce_ticks        <= RST_DEBOUNCE;
            cfg_reg.backoff_ticks         <= RST_BACKOFF;
            cfg_reg.packet_gap_ticks      <= RST_GAP;
            cfg_reg.retry_limit           <= RST_RETRY_LIM;
            cfg_reg.packet_total          <= RST_PKT_TOTAL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OBSERVE:   cfg_reg.observe_ticks         <= cfg_data;
                REG_TIMEOUT:   cfg_reg.connect_timeout_ticks <= cfg_data;
                REG_DEBOUNCE:  cfg_reg.debounce_ticks        <= cfg_data;
                REG_BACKOFF:   cfg_reg.backoff_ticks         <= cfg_data;
                REG_GAP:       cfg_reg.packet_gap_ticks      <= cfg_data;
                REG_RETRY_LIM: cfg_reg.retry_limit           <= cfg_data[CNT_W-1:0];
                REG_PKT_TOTAL: cfg_reg.packet_total          <= cfg_data[CNT_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= cmd;
            host_reg <= host_active;
            link_reg <= link_status;
        end
    end

    wrs_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .cmd               (cmd_reg),
        .host_active       (host_reg),
        .link_status       (link_reg),
        .cfg               (cfg_reg),
        .phase_cur         (phase_reg),
        .phase_timer_cur   (phase_timer_reg),
        .since_attempt_cur (since_attempt_reg),
        .attempt_seen_cur  (attempt_seen_reg),
        .retry_count_cur   (retry_count_reg),
        .sent_count_cur    (sent_count_reg),
        .phase_nxt         (phase_next),
        .phase_timer_nxt   (phase_timer_next),
        .since_attempt_nxt (since_attempt_next),
        .attempt_seen_nxt  (attempt_seen_next),
        .retry_count_nxt   (retry_count_next),
        .sent_count_nxt    (sent_count_next),
        .res               (res_next)
    );

    // sequencer state, updated as each item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            phase_timer_reg   <= '0;
            since_attempt_reg <= '0;
            attempt_seen_reg  <= 1'b0;
            retry_count_reg   <= '0;
            sent_count_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg         <= phase_next;
            phase_timer_reg   <= phase_timer_next;
            since_attempt_reg <= since_attempt_next;
            attempt_seen_reg  <= attempt_seen_next;
            retry_count_reg   <= retry_count_next;
            sent_count_reg    <= sent_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign phase            = res_reg.phase;
    assign request_taken    = res_reg.request_taken;
    assign hold_poweroff    = res_reg.hold_poweroff;
    assign release_poweroff = res_reg.release_poweroff;
    assign start_link       = res_reg.start_link;
    assign send_packet      = res_reg.send_packet;
    assign link_down        = res_reg.link_down;
    assign retries_used     = res_reg.retries_used;

    `WRS_ASSERT(a_taken_observe, out_valid && request_taken |-> phase == PH_OBSERVE, "request taken outside observe")
    `WRS_ASSERT(a_one_pulse, out_valid |-> $onehot0({request_taken, release_poweroff, start_link, send_packet, link_down}), "more than one sequencer pulse")
    `WRS_ASSERT(a_down_idle, out_valid && link_down |-> phase == PH_IDLE, "link down without return to idle")
    `WRS_ASSERT_ALWAYS(a_ready_empty, !out_valid_reg |-> in_ready, "input stalled with empty output")

endmodule

`default_nettype wire
